/* hw/rtl/vt220_key_sequence_decoder_macros.svh */
// Assertion macros shared by the VT220 key decoder RTL.
`ifndef VT220_KEY_SEQUENCE_DECODER_MACROS_SVH
`define VT220_KEY_SEQUENCE_DECODER_MACROS_SVH

`ifndef SYNTH
// Clocked check that is held off while reset is asserted.
`define VKD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("vkd assertion failed");
// Clocked check that also holds during reset.
`define VKD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("vkd assertion failed");
`else
`define VKD_ASSERT(lbl, clk, rstn, prop)
`define VKD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hw/rtl/vkd_pkg.sv */
// Package with the types and constants of the VT220 key sequence decoder.
package vkd_pkg;

    typedef enum logic [5:0] {
        PS_IDLE  = 6'b000001,
        PS_ESC   = 6'b000010,
        PS_SS3   = 6'b000100,
        PS_CSI   = 6'b001000,
        PS_PARAM = 6'b010000,
        PS_TAIL  = 6'b100000
    } parse_state_t;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_UNK  = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SS3      = 8'h4F;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_P        = 8'h50;
    localparam logic [7:0] CH_S        = 8'h53;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_1        = 8'h31;
    localparam logic [7:0] CH_3        = 8'h33;
    localparam logic [7:0] CH_6        = 8'h36;
    localparam logic [7:0] CH_9        = 8'h39;

    localparam logic [4:0] KEY_UP   = 5'd0;
    localparam logic [4:0] KEY_PF1  = 5'd4;
    localparam logic [4:0] KEY_FIND = 5'd8;
    localparam logic [4:0] KEY_F7   = 5'd14;
    localparam logic [4:0] KEY_F11  = 5'd18;
    localparam logic [4:0] KEY_F17  = 5'd22;
    localparam logic [4:0] KEY_LAST = 5'd25;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] key_kind;
        logic [7:0] char_value;
        logic [4:0] key_id;
    } result_t;

endpackage

/* hw/rtl/vkd_input_stage.sv */
// Input register of the VT220 key decoder: holds one received byte.
module vkd_input_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    input  logic             take,
    output vkd_pkg::in_item_t item
);
    import vkd_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

/* hw/rtl/vkd_parse_core.sv */
// Sequence parser of the VT220 key decoder: parse state and result decode.
`include "vt220_key_sequence_decoder_macros.svh"

module vkd_parse_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  vkd_pkg::in_item_t item,
    input  logic             out_free,
    output logic             take,
    output vkd_pkg::result_t res
);
    import vkd_pkg::*;

    typedef struct packed {
        logic       known;
        logic [4:0] key;
    } fkey_t;

    // Two-digit function key code: tens digit 1..3, units digit 0..9.
    function automatic fkey_t fkey_lookup(input logic [1:0] tens, input logic [3:0] units);
        fkey_t r;
        r = '0;
        case (tens)
            2'd1: begin
                if (units >= 4'd8 && units <= 4'd9) begin
                    r.known = 1'b1;
                    r.key   = KEY_F7 + 5'(units - 4'd8);
                end
            end
            2'd2: begin
                if (units <= 4'd1) begin
                    r.known = 1'b1;
                    r.key   = KEY_F7 + 5'd2 + 5'(units);
                end else if (units >= 4'd3 && units <= 4'd6) begin
                    r.known = 1'b1;
                    r.key   = KEY_F11 + 5'(units - 4'd3);
                end
            end
            2'd3: begin
                if (units >= 4'd1 && units <= 4'd4) begin
                    r.known = 1'b1;
                    r.key   = KEY_F17 + 5'(units - 4'd1);
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    parse_state_t state_reg, state_next;
    logic [7:0]   saved_digit_reg, saved_digit_next;
    logic [4:0]   pending_key_reg, pending_key_next;
    logic         pending_known_reg, pending_known_next;
    logic         skip_nul_reg;
    logic [7:0]   b;
    logic         skip;
    fkey_t        fk;

    assign take = out_free;
    assign b    = item.rx_byte;
    assign skip = skip_nul_reg && (b == CH_NUL);
    assign fk   = fkey_lookup(saved_digit_reg[1:0], b[3:0]);

    always_comb begin
        state_next         = state_reg;
        saved_digit_next   = saved_digit_reg;
        pending_key_next   = pending_key_reg;
        pending_known_next = pending_known_reg;
        res                = '0;
        if (item.valid && take && !skip) begin
            case (state_reg)
                PS_ESC: begin
                    if (b == CH_NUL) begin
                        state_next     = PS_IDLE;
                        res.valid      = 1'b1;
                        res.key_kind   = KIND_CHAR;
                        res.char_value = CH_ESC;
                    end else if (b == CH_LBRACKET) begin
                        state_next = PS_CSI;
                    end else if (b == CH_SS3) begin
                        state_next = PS_SS3;
                    end else begin
                        state_next   = PS_IDLE;
                        res.valid    = 1'b1;
                        res.key_kind = KIND_UNK;
                    end
                end
                PS_SS3: begin
                    state_next = PS_IDLE;
                    res.valid  = 1'b1;
                    if (b >= CH_P && b <= CH_S) begin
                        res.key_kind = KIND_KEY;
                        res.key_id   = KEY_PF1 + 5'(b - CH_P);
                    end else if (b >= CH_A && b <= CH_D) begin
                        res.key_kind = KIND_KEY;
                        res.key_id   = KEY_UP + 5'(b - CH_A);
                    end else begin
                        res.key_kind = KIND_UNK;
                    end
                end
                PS_CSI: begin
                    if (b >= CH_A && b <= CH_D) begin
                        state_next   = PS_IDLE;
                        res.valid    = 1'b1;
                        res.key_kind = KIND_KEY;
                        res.key_id   = KEY_UP + 5'(b - CH_A);
                    end else begin
                        saved_digit_next = b;
                        state_next       = PS_PARAM;
                    end
                end
                PS_PARAM: begin
                    if (b == CH_NUL) begin
                        state_next   = PS_IDLE;
                        res.valid    = 1'b1;
                        res.key_kind = KIND_UNK;
                    end else if (b == CH_TILDE) begin
                        state_next = PS_IDLE;
                        res.valid  = 1'b1;
                        if (saved_digit_reg >= CH_1 && saved_digit_reg <= CH_6) begin
                            res.key_kind = KIND_KEY;
                            res.key_id   = KEY_FIND + 5'(saved_digit_reg - CH_1);
                        end else begin
                            res.key_kind = KIND_UNK;
                        end
                    end else begin
                        state_next = PS_TAIL;
                        if (saved_digit_reg >= CH_1 && saved_digit_reg <= CH_3
                                && b >= CH_0 && b <= CH_9) begin
                            pending_known_next = fk.known;
                            pending_key_next   = fk.key;
                        end else begin
                            pending_known_next = 1'b0;
                            pending_key_next   = '0;
                        end
                    end
                end
                PS_TAIL: begin
                    state_next = PS_IDLE;
                    res.valid  = 1'b1;
                    if (pending_known_reg) begin
                        res.key_kind = KIND_KEY;
                        res.key_id   = pending_key_reg;
                    end else begin
                        res.key_kind = KIND_UNK;
                    end
                end
                default: begin
                    state_next = PS_IDLE;
                    if (b == CH_ESC) begin
                        state_next = PS_ESC;
                    end else begin
                        res.valid      = 1'b1;
                        res.key_kind   = KIND_CHAR;
                        res.char_value = (b == CH_CR || b == CH_LF) ? CH_LF : b;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= PS_IDLE;
            saved_digit_reg   <= '0;
            pending_key_reg   <= '0;
            pending_known_reg <= 1'b0;
            skip_nul_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            saved_digit_reg   <= saved_digit_next;
            pending_key_reg   <= pending_key_next;
            pending_known_reg <= pending_known_next;
            if (cfg_we) begin
                skip_nul_reg <= cfg_wdata;
            end
        end
    end

    `VKD_ASSERT(a_esc_enters_seq, aclk, aresetn,
        item.valid && take && !skip && state_reg == PS_IDLE && b == CH_ESC |=> state_reg == PS_ESC)
    `VKD_ASSERT(a_tail_returns_idle, aclk, aresetn,
        item.valid && take && !skip && state_reg == PS_TAIL |=> state_reg == PS_IDLE)
    `VKD_ASSERT(a_key_has_no_char, aclk, aresetn,
        res.valid && res.key_kind != KIND_CHAR |-> res.char_value == CH_NUL)

endmodule

/* hw/rtl/vkd_result_reg.sv */
// Result register of the VT220 key decoder: holds one decoded key until taken.
`include "vt220_key_sequence_decoder_macros.svh"

module vkd_result_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  vkd_pkg::result_t res,
    input  logic             load,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_key_kind,
    output logic [7:0]       m_char_value,
    output logic [4:0]       m_key_id
);
    import vkd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res.valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.valid) begin
            data_reg <= res;
        end
    end

    assign m_valid      = valid_reg;
    assign m_key_kind   = data_reg.key_kind;
    assign m_char_value = data_reg.char_value;
    assign m_key_id     = data_reg.key_id;

    `VKD_ASSERT(a_valid_key_range, aclk, aresetn,
        m_valid |-> m_key_kind != KIND_RSVD && (m_key_kind != KIND_KEY || m_key_id <= KEY_LAST))

endmodule

/* hw/rtl/vt220_key_sequence_decoder.sv */
// Top level of the VT220 keyboard escape sequence decoder.
//
//  Channel   Direction  Handshake          Carries
//  s_        in         s_valid/s_ready    s_rx_byte, one keyboard byte
//  m_        out        m_valid/m_ready    m_key_kind, m_char_value, m_key_id
//  cfg_      in         cfg_we             cfg_wdata, skip_nul_bytes (poll mode)
//
// A byte accepted on the input channel lands in the input register; once
// the result register is free, the parser decodes it against the current
// parse state and, if it completes a key, writes the result register. The
// decoded key is then offered on m_valid from the result register.
// One byte is taken every cycle while results are drained; the combinational
// decode between the input register and the result register sets that rate.
// Reset is synchronous and active low and leaves the parser idle with poll
// mode off. When m_ready is held low with a result waiting, the input
// register takes one more byte and then s_ready drops.
// Bytes that only advance a sequence (ESC, ESC [ and so on) produce no
// result transaction, and in poll mode NUL bytes are absorbed silently.
module vt220_key_sequence_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_key_kind,
    output logic [7:0] m_char_value,
    output logic [4:0] m_key_id
);
    import vkd_pkg::*;

    in_item_t item;
    result_t  res;
    logic     take;
    logic     out_free;

    // Input register: decouples the sender from the parser.
    vkd_input_stage u_input (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .take      (take),
        .item      (item)
    );

    // Parser: walks the escape sequence state and decides the key.
    vkd_parse_core u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .out_free  (out_free),
        .take      (take),
        .res       (res)
    );

    // Result register: holds a decoded key until the receiver takes it.
    vkd_result_reg u_result (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .res          (res),
        .load         (item.valid && take),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_kind   (m_key_kind),
        .m_char_value (m_char_value),
        .m_key_id     (m_key_id)
    );

endmodule
